/* hdl/amc_pkg.sv */
// ----------------------------------------------------------------------------
// amc_pkg
// Shared types, opcodes and sizes for the accumulator machine core.
// ----------------------------------------------------------------------------
package amc_pkg;

    localparam int MEM_WORDS = 256;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int PC_W      = ADDR_W + 1;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(DATA_W);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_HALTED  = 2'd3
    } status_t;

    localparam logic [7:0] OP_READ       = 8'd1;
    localparam logic [7:0] OP_WRITE      = 8'd2;
    localparam logic [7:0] OP_LOAD       = 8'd3;
    localparam logic [7:0] OP_STORE      = 8'd4;
    localparam logic [7:0] OP_ADD        = 8'd5;
    localparam logic [7:0] OP_SUB        = 8'd6;
    localparam logic [7:0] OP_MUL        = 8'd7;
    localparam logic [7:0] OP_DIV        = 8'd8;
    localparam logic [7:0] OP_MOD        = 8'd9;
    localparam logic [7:0] OP_BRANCH     = 8'd10;
    localparam logic [7:0] OP_BRANCHNEG  = 8'd11;
    localparam logic [7:0] OP_BRANCHZERO = 8'd12;
    localparam logic [7:0] OP_HALT       = 8'd13;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_FETCH,
        S_FETCH_WAIT,
        S_OPER,
        S_OPER_WAIT,
        S_EXEC,
        S_DIV_RUN,
        S_DONE
    } state_t;

    // divider handshake
    typedef struct packed {
        logic start;
        logic is_mod;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

endpackage

/* hdl/amc_divider.sv */
// ----------------------------------------------------------------------------
// amc_divider
// Bit-serial signed divide and modulo, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amc_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  amc_pkg::div_req_t             req,
    input  logic [amc_pkg::DATA_W-1:0]    dividend,
    input  logic [amc_pkg::DATA_W-1:0]    divisor,
    output amc_pkg::div_rsp_t             rsp,
    output logic [amc_pkg::DATA_W-1:0]    result
);
    import amc_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              negq_reg, negq_next;
    logic              negr_reg, negr_next;
    logic              mod_reg, mod_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] shifted;
    logic [DATA_W-1:0] q_out;
    logic [DATA_W-1:0] r_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        mod_reg  <= mod_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        mod_next  = mod_reg;
        shifted   = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
        trial     = {1'b0, shifted} - {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            rem_next  = '0;
            negq_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            negr_next = dividend[DATA_W-1];
            mod_next  = req.is_mod;
        end
        else if (busy_reg)
        begin
            // restoring step, remainder top bit is always clear
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
            end
            else
            begin
                rem_next = shifted;
            end
            quo_next = {quo_reg[DATA_W-2:0], ~trial[DATA_W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign q_out    = negq_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign r_out    = negr_reg ? (~rem_reg + 1'b1) : rem_reg;
    assign result   = mod_reg ? r_out : q_out;
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without run");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> cnt_reg == '0)
        else $error("divider count not cleared");

endmodule

/* hdl/accumulator_machine_core.sv */
// ----------------------------------------------------------------------------
// accumulator_machine_core
// Single-accumulator machine with 256-word program and data memory.
// ----------------------------------------------------------------------------
// load, start, unused command and step while halted: S_FETCH, S_DONE, strobe;
// step: S_FETCH, S_FETCH_WAIT, S_OPER, S_OPER_WAIT, S_EXEC, S_DONE; DIV/MOD
// with a nonzero divisor adds S_DIV_RUN, paced by the bit-serial divider
// (one bit per cycle). next item can be taken at the edge that ends the
// strobe. busy is low only in idle. after reset a clearing pass sweeps all
// 256 words to zero with busy high. results cannot be stalled by the receiver.
module accumulator_machine_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      command,
    input  logic [7:0]                      load_address,
    input  logic signed [31:0]              load_data,
    input  logic signed [31:0]              read_value,
    output logic                            done,
    output logic [8:0]                      next_pc,
    output logic signed [31:0]              acc_value,
    output logic                            write_valid,
    output logic signed [31:0]              write_value,
    output logic [7:0]                      executed_op,
    output logic [1:0]                      status
);
    import amc_pkg::*;

    logic [DATA_W-1:0] mem [MEM_WORDS];
    logic [DATA_W-1:0] rdata_reg;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;

    state_t            state_reg, state_next;
    logic [ADDR_W:0]   clr_reg, clr_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              halt_reg, halt_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [ADDR_W-1:0] la_reg, la_next;
    logic [DATA_W-1:0] ld_reg, ld_next;
    logic [DATA_W-1:0] rv_reg, rv_next;
    logic [DATA_W-1:0] word_reg, word_next;
    logic              done_reg, done_next;
    logic [PC_W-1:0]   npc_reg, npc_next;
    logic              wv_reg, wv_next;
    logic [DATA_W-1:0] wval_reg, wval_next;
    logic [7:0]        op_reg, op_next;
    status_t           st_reg, st_next;
    logic [2*DATA_W-1:0] prod;
    logic [7:0]        op;
    logic [ADDR_W-1:0] opnd;
    logic [PC_W-1:0]   seq_pc;
    logic [PC_W-1:0]   tgt;
    logic              halted_after;
    div_req_t          dreq;
    div_rsp_t          drsp;
    logic [DATA_W-1:0] dres;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    amc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .dividend (acc_reg),
        .divisor  (rdata_reg),
        .rsp      (drsp),
        .result   (dres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            acc_reg   <= '0;
            pc_reg    <= '0;
            halt_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            acc_reg   <= acc_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        la_reg   <= la_next;
        ld_reg   <= ld_next;
        rv_reg   <= rv_next;
        word_reg <= word_next;
        npc_reg  <= npc_next;
        wv_reg   <= wv_next;
        wval_reg <= wval_next;
        op_reg   <= op_next;
        st_reg   <= st_next;
    end

    assign op     = word_reg[23:16];
    assign opnd   = word_reg[ADDR_W-1:0];
    assign seq_pc = pc_reg + 1'b1;
    assign tgt    = {1'b0, opnd};
    assign prod   = acc_reg * rdata_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        acc_next   = acc_reg;
        pc_next    = pc_reg;
        halt_next  = halt_reg;
        done_next  = 1'b0;
        cmd_next   = cmd_reg;
        la_next    = la_reg;
        ld_next    = ld_reg;
        rv_next    = rv_reg;
        word_next  = word_reg;
        npc_next   = npc_reg;
        wv_next    = wv_reg;
        wval_next  = wval_reg;
        op_next    = op_reg;
        st_next    = st_reg;
        we         = 1'b0;
        waddr      = la_reg;
        wdata      = ld_reg;
        raddr      = pc_reg[ADDR_W-1:0];
        dreq       = '0;
        halted_after = halt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[ADDR_W-1:0];
                wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (ADDR_W+1)'(MEM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = command;
                    la_next   = load_address;
                    ld_next   = load_data;
                    rv_next   = read_value;
                    wv_next   = 1'b0;
                    wval_next = '0;
                    op_next   = '0;
                    st_next   = ST_OK;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                unique case (cmd_reg)
                    CMD_LOAD:
                    begin
                        we = 1'b1;
                        state_next = S_DONE;
                    end
                    CMD_START:
                    begin
                        acc_next  = '0;
                        pc_next   = '0;
                        halt_next = 1'b0;
                        state_next = S_DONE;
                    end
                    CMD_STEP:
                    begin
                        if (halt_reg || pc_reg[ADDR_W])
                        begin
                            halt_next  = 1'b1;
                            st_next    = ST_HALTED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FETCH_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FETCH_WAIT:
            begin
                state_next = S_OPER;
            end
            S_OPER:
            begin
                word_next  = rdata_reg;
                raddr      = rdata_reg[ADDR_W-1:0];
                state_next = S_OPER_WAIT;
            end
            S_OPER_WAIT:
            begin
                raddr      = opnd;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                op_next = op;
                npc_next = seq_pc;
                state_next = S_DONE;
                case (op)
                    OP_READ:  acc_next = rv_reg;
                    OP_WRITE:
                    begin
                        wv_next   = 1'b1;
                        wval_next = acc_reg;
                    end
                    OP_LOAD:  acc_next = rdata_reg;
                    OP_STORE:
                    begin
                        we    = 1'b1;
                        waddr = opnd;
                        wdata = acc_reg;
                    end
                    OP_ADD:   acc_next = acc_reg + rdata_reg;
                    OP_SUB:   acc_next = acc_reg - rdata_reg;
                    OP_MUL:   acc_next = prod[DATA_W-1:0];
                    OP_DIV, OP_MOD:
                    begin
                        if (rdata_reg == '0)
                        begin
                            st_next = ST_DIVZERO;
                        end
                        else
                        begin
                            dreq.start  = 1'b1;
                            dreq.is_mod = (op == OP_MOD);
                            state_next  = S_DIV_RUN;
                        end
                    end
                    OP_BRANCH:     npc_next = tgt;
                    OP_BRANCHNEG:
                    begin
                        if (acc_reg[DATA_W-1])
                        begin
                            npc_next = tgt;
                        end
                    end
                    OP_BRANCHZERO:
                    begin
                        if (acc_reg == '0)
                        begin
                            npc_next = tgt;
                        end
                    end
                    OP_HALT:
                    begin
                        halted_after = 1'b1;
                        npc_next = pc_reg;
                    end
                    default:  st_next = ST_INVALID;
                endcase
                if (npc_next[ADDR_W])
                begin
                    npc_next = PC_W'(MEM_WORDS);
                    halted_after = 1'b1;
                end
                halt_next = halted_after;
                pc_next   = npc_next;
                if (state_next == S_DONE && st_next == ST_OK && halted_after)
                begin
                    st_next = ST_HALTED;
                end
            end
            S_DIV_RUN:
            begin
                if (drsp.done)
                begin
                    acc_next = dres;
                    if (halt_reg)
                    begin
                        st_next = ST_HALTED;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign next_pc     = pc_reg;
    assign acc_value   = acc_reg;
    assign write_valid = wv_reg;
    assign write_value = wval_reg;
    assign executed_op = op_reg;
    assign status      = st_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe outside idle");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg[ADDR_W] |-> (pc_reg[ADDR_W-1:0] == '0) && halt_reg)
        else $error("program counter past end without halt");
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.busy |-> state_reg == S_DIV_RUN)
        else $error("divider running outside divide state");

endmodule
